// ===== hw/rtl/esp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esp_pkg: shared types and constants of the expiring slot pool
// Command codes, stream item layouts, register map and parameter defaults.
// ----------------------------------------------------------------------------
package esp_pkg;

	localparam int POOL_SIZE_DEF = 2048;
	localparam int TIME_BITS_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int TICK_W  = 32;
	localparam int SLOT_W  = 11;
	localparam int FREED_W = 12;
	localparam int CFG_W   = 12;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 24;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd2;

	// register index, taken from paddr above the byte offset
	localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;
	localparam int SLOTS_RESET = 2048;

	typedef struct packed {
		logic [TICK_W-1:0] lifetime;
		logic [TICK_W-1:0] now;
		logic              list_select;
		logic [CMD_W-1:0]  cmd;
	} item_t;

	typedef struct packed {
		logic [FREED_W-1:0] freed_count;
		logic               granted;
		logic [SLOT_W-1:0]  slot;
	} result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/esp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module esp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/esp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esp_ctrl: list sequencer of the expiring slot pool
// Holds the link and expiry memories and list heads; clear writes the links,
// allocate and sweep run read-modify-write sequences on the link memory.
// ----------------------------------------------------------------------------
module esp_ctrl #(
	parameter int POOL_SIZE = esp_pkg::POOL_SIZE_DEF,
	parameter int TIME_BITS = esp_pkg::TIME_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [esp_pkg::CFG_W-1:0]  slots_in_use,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire esp_pkg::item_t             in_item,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output esp_pkg::result_t                out_res
);

	localparam int IDX_W = $clog2(POOL_SIZE);
	localparam int LW    = IDX_W + 1;             // {valid, index}
	localparam int CNT_W = $clog2(POOL_SIZE + 1);
	localparam logic [LW-1:0] NULL_LINK = '0;
	localparam logic [LW-1:0] LINK_ZERO = {1'b1, {IDX_W{1'b0}}};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_A_RD  = 3'd2;
	localparam logic [2:0] ST_A_WR  = 3'd3;
	localparam logic [2:0] ST_S_RD  = 3'd4;
	localparam logic [2:0] ST_S_EV  = 3'd5;
	localparam logic [2:0] ST_S_FIX = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]                   state_q;
	logic                         list_sel_q;
	logic [TIME_BITS-1:0]         now_q;
	logic [TIME_BITS-1:0]         life_q;
	logic [LW-1:0]                free_q;
	logic [LW-1:0]                ord_q;
	logic [LW-1:0]                trc_q;
	logic [LW-1:0]                cur_q;
	logic [LW-1:0]                prev_q;
	logic [LW-1:0]                nxt_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [esp_pkg::FREED_W-1:0]  freed_q;
	logic [IDX_W-1:0]             res_slot_q;
	logic                         res_gnt_q;
	logic                         out_valid_q;
	esp_pkg::result_t             out_res_q;

	logic [LW-1:0]        sel_head;
	logic [CNT_W-1:0]     n_lim;
	logic [CNT_W-1:0]     cnt_nx;
	logic                 accept;
	logic                 fin_go;
	logic [LW-1:0]        link_rd;
	logic [TIME_BITS-1:0] exp_rd;
	logic                 expired;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] exp_new;
	logic [IDX_W-1:0]     raddr;
	logic                 link_we;
	logic [IDX_W-1:0]     link_waddr;
	logic [LW-1:0]        link_wdata;
	logic                 exp_we;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	assign sel_head = list_sel_q ? trc_q : ord_q;
	assign n_lim    = CNT_W'(slots_in_use);
	assign cnt_nx   = cnt_q + CNT_W'(1);
	assign expired  = exp_rd < now_q;
	// a carry out of the add means the stamp saturates
	assign sum      = {1'b0, now_q} + {1'b0, life_q};
	assign exp_new  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	assign raddr    = (state_q == ST_A_RD) ? free_q[IDX_W-1:0] : cur_q[IDX_W-1:0];
	assign exp_we   = (state_q == ST_A_WR);

	always_comb begin
		link_we    = 1'b0;
		link_waddr = cur_q[IDX_W-1:0];
		link_wdata = free_q;
		case (state_q)
			ST_CLEAR: begin
				link_we    = cnt_q < n_lim;
				link_waddr = cnt_q[IDX_W-1:0];
				link_wdata = (cnt_nx < n_lim) ? {1'b1, cnt_nx[IDX_W-1:0]} : NULL_LINK;
			end
			ST_A_WR: begin
				link_we    = 1'b1;
				link_waddr = free_q[IDX_W-1:0];
				link_wdata = sel_head;
			end
			ST_S_EV: begin
				link_we    = expired;
				link_waddr = cur_q[IDX_W-1:0];
				link_wdata = free_q;
			end
			ST_S_FIX: begin
				link_we    = 1'b1;
				link_waddr = prev_q[IDX_W-1:0];
				link_wdata = nxt_q;
			end
			default: begin
				link_we = 1'b0;
			end
		endcase
	end

	esp_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (raddr),
		.rdata (link_rd)
	);

	esp_ram #(.WIDTH(TIME_BITS), .DEPTH(POOL_SIZE)) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (free_q[IDX_W-1:0]),
		.wdata (exp_new),
		.raddr (raddr),
		.rdata (exp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_q      <= NULL_LINK;
			ord_q       <= NULL_LINK;
			trc_q       <= NULL_LINK;
			cur_q       <= NULL_LINK;
			prev_q      <= NULL_LINK;
			nxt_q       <= NULL_LINK;
			cnt_q       <= '0;
			freed_q     <= '0;
			res_slot_q  <= '0;
			res_gnt_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_slot_q <= '0;
						res_gnt_q  <= 1'b0;
						freed_q    <= '0;
						cnt_q      <= '0;
						case (in_item.cmd)
							esp_pkg::CMD_CLEAR: state_q <= ST_CLEAR;
							esp_pkg::CMD_ALLOC: state_q <= free_q[IDX_W] ? ST_A_RD : ST_FIN;
							esp_pkg::CMD_SWEEP: begin
								cur_q   <= in_item.list_select ? trc_q : ord_q;
								prev_q  <= NULL_LINK;
								state_q <= ST_S_RD;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CLEAR: begin
					if (cnt_q < n_lim) begin
						cnt_q <= cnt_nx;
					end else begin
						free_q  <= (n_lim != '0) ? LINK_ZERO : NULL_LINK;
						ord_q   <= NULL_LINK;
						trc_q   <= NULL_LINK;
						state_q <= ST_FIN;
					end
				end
				ST_A_RD: state_q <= ST_A_WR;
				ST_A_WR: begin
					free_q <= link_rd;
					if (list_sel_q) begin
						trc_q <= free_q;
					end else begin
						ord_q <= free_q;
					end
					res_slot_q <= free_q[IDX_W-1:0];
					res_gnt_q  <= 1'b1;
					state_q    <= ST_FIN;
				end
				ST_S_RD: begin
					if (!cur_q[IDX_W] || cnt_q == CNT_W'(POOL_SIZE)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_S_EV;
					end
				end
				ST_S_EV: begin
					cnt_q <= cnt_nx;
					cur_q <= link_rd;
					if (expired) begin
						free_q  <= cur_q;
						freed_q <= freed_q + esp_pkg::FREED_W'(1);
						nxt_q   <= link_rd;
						if (prev_q[IDX_W]) begin
							state_q <= ST_S_FIX;
						end else begin
							// unlinking the list head
							if (list_sel_q) begin
								trc_q <= link_rd;
							end else begin
								ord_q <= link_rd;
							end
							state_q <= ST_S_RD;
						end
					end else begin
						prev_q  <= cur_q;
						state_q <= ST_S_RD;
					end
				end
				ST_S_FIX: state_q <= ST_S_RD;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			list_sel_q <= in_item.list_select;
			now_q      <= TIME_BITS'(in_item.now);
			life_q     <= TIME_BITS'(in_item.lifetime);
		end
		if (fin_go) begin
			out_res_q.slot        <= esp_pkg::SLOT_W'(res_slot_q);
			out_res_q.granted     <= res_gnt_q;
			out_res_q.freed_count <= freed_q;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/expiring_slot_pool_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// expiring_slot_pool_top: slot pool with free list and two expiring lists
// Stream command port, stream result port, APB register for slots_in_use.
// ----------------------------------------------------------------------------
// One command is worked at a time and every command gives one result. The
// pace is set by the link memory, which takes one write and one registered
// read per cycle: allocate reads the free-list head and then writes its link
// (straight to the result when the free list is empty, as for an undefined
// command), clear writes slots_in_use links, one link written per cycle, and
// a sweep reads and checks each slot of the list in turn, with a second link
// write for each freed slot that had a surviving predecessor. The link
// and expiry memories have no reset; a clear must precede allocation, and
// lists are empty after reset. A result held on the output does not stop a
// new command from being taken.
module expiring_slot_pool_top #(
	parameter int POOL_SIZE = esp_pkg::POOL_SIZE_DEF,
	parameter int TIME_BITS = esp_pkg::TIME_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// cmd[1:0], now[33:2], lifetime[65:34], zero pad[71:66]
	input  wire logic [esp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// list_select[0]
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// slot[10:0], freed_count[22:11], zero pad[23]
	output logic      [esp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// granted[0]
	output logic                                  m_axis_tuser,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [esp_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [esp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [esp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready
);

	localparam int SLOTS_RST_INT = (esp_pkg::SLOTS_RESET < POOL_SIZE) ?
		esp_pkg::SLOTS_RESET : POOL_SIZE;
	localparam logic [esp_pkg::CFG_W-1:0] SLOTS_RST = esp_pkg::CFG_W'(SLOTS_RST_INT);

	logic [esp_pkg::CFG_W-1:0] slots_q;
	logic                      cfg_wr;
	logic                      reg_hit;
	logic [esp_pkg::CFG_W-1:0] wr_val;
	esp_pkg::item_t            item;
	esp_pkg::result_t          res;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[esp_pkg::APB_ADDR_W-1:2] == esp_pkg::REG_SLOTS_IN_USE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign wr_val  = pwdata[esp_pkg::CFG_W-1:0];
	assign prdata  = reg_hit ? esp_pkg::APB_DATA_W'(slots_q) : '0;

	// values above the pool size act as the pool size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_RST;
		end else if (cfg_wr) begin
			if (32'(wr_val) > 32'(POOL_SIZE)) begin
				slots_q <= esp_pkg::CFG_W'(POOL_SIZE);
			end else begin
				slots_q <= wr_val;
			end
		end
	end

	assign item.cmd         = s_axis_tdata[1:0];
	assign item.now         = s_axis_tdata[33:2];
	assign item.lifetime    = s_axis_tdata[65:34];
	assign item.list_select = s_axis_tuser;

	esp_ctrl #(.POOL_SIZE(POOL_SIZE), .TIME_BITS(TIME_BITS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.slots_in_use (slots_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_item      (item),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_res      (res)
	);

	assign m_axis_tdata = {1'b0, res.freed_count, res.slot};
	assign m_axis_tuser = res.granted;

	// one command in flight: no transfer in the cycle after one is taken
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command taken while another is in flight");

	a_grant_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[22:11] == 12'd0)
		else $error("granted result carries a freed count");

	a_nogrant_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[10:0] == 11'd0)
		else $error("slot index without grant");

	a_slots_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> 32'(slots_q) <= 32'(POOL_SIZE))
		else $error("slots_in_use beyond pool size");

endmodule
`default_nettype wire

// ===== sim/tb_expiring_slot_pool_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expiring_slot_pool_top: self-checking bench for the expiring slot pool
// A short table of directed commands covers the pool before the first clear,
// saturated expiry, expiry equal to now, an exhausted free list, odd register
// values and the undefined command. Random phases then sweep the pool size,
// run all four commands on a creeping time base, throttle both stream sides.
// Results are checked against typed table rows, else a behavioral pool copy.
// ----------------------------------------------------------------------------
module tb_expiring_slot_pool_top;
	import esp_pkg::*;

	localparam int POOL = POOL_SIZE_DEF;
	localparam int NIL = POOL;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int STALL_LIMIT = 50000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_DIR = 28;
	localparam int N_PHASE = 12;
	localparam int ITEMS_PER_PHASE = 48;

	typedef struct packed {
		logic              is_cfg;
		logic [31:0]       cfg_val;
		logic [CMD_W-1:0]  cmd;
		logic              sel;
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] life;
		logic              typed;
		logic [SLOT_W-1:0] w_slot;
		logic              w_granted;
		logic [FREED_W-1:0] w_freed;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	expiring_slot_pool_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// behavioral pool
	logic [11:0]       succ [POOL];
	logic              succ_ok [POOL];
	logic [TICK_W-1:0] stamp [POOL];
	int unsigned       free_top;
	int unsigned       ord_top;
	int unsigned       trc_top;
	int unsigned       pool_len;

	result_t pending_answers [$];
	int      fail_count;
	int      snd_idle;
	int      rcv_idle;
	int      hold_req;
	int      stall_cycles;
	row_t    dir_rows [0:N_DIR-1];

	function automatic int unsigned succ_of(input int unsigned s);
		if (s >= POOL || !succ_ok[s])
			return NIL;
		return (succ[s] < POOL) ? succ[s] : NIL;
	endfunction

	function automatic void set_succ(input int unsigned s, input int unsigned to);
		if (to < POOL) begin
			succ[s] = 12'(to);
			succ_ok[s] = 1'b1;
		end else begin
			succ[s] = '0;
			succ_ok[s] = 1'b0;
		end
	endfunction

	function automatic result_t pool_answer(input logic [CMD_W-1:0] op, input logic sel,
			input logic [TICK_W-1:0] now, input logic [TICK_W-1:0] life);
		result_t     r;
		int unsigned top, cur, prv, nxt, p, i;
		logic [TICK_W:0] sum;
		r = '0;
		top = sel ? trc_top : ord_top;
		case (op)
			CMD_CLEAR: begin
				for (i = 0; i < pool_len; i++)
					set_succ(i, (i + 1 < pool_len) ? i + 1 : NIL);
				free_top = (pool_len != 0) ? 0 : NIL;
				ord_top = NIL;
				trc_top = NIL;
			end
			CMD_ALLOC: begin
				if (free_top < POOL) begin
					p = free_top;
					free_top = succ_of(p);
					set_succ(p, top);
					top = p;
					sum = {1'b0, now} + {1'b0, life};
					stamp[p] = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
					r.slot = SLOT_W'(p);
					r.granted = 1'b1;
				end
			end
			CMD_SWEEP: begin
				cur = top;
				prv = NIL;
				for (i = 0; i < POOL && cur < POOL; i++) begin
					nxt = succ_of(cur);
					if (stamp[cur] < now) begin
						if (prv == NIL)
							top = nxt;
						else
							set_succ(prv, nxt);
						set_succ(cur, free_top);
						free_top = cur;
						r.freed_count = r.freed_count + 1'b1;
					end else begin
						prv = cur;
					end
					cur = nxt;
				end
			end
			default: ;
		endcase
		if (op == CMD_ALLOC || op == CMD_SWEEP) begin
			if (sel)
				trc_top = top;
			else
				ord_top = top;
		end
		return r;
	endfunction

	// called on a falling edge; returns on the falling edge after the transfer
	task automatic issue(input logic [CMD_W-1:0] op, input logic sel,
			input logic [TICK_W-1:0] now, input logic [TICK_W-1:0] life,
			input logic typed, input result_t want);
		result_t got;
		while ($urandom_range(0, 99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, life, now, op};
		s_axis_tuser <= sel;
		do @(posedge clk); while (!s_axis_tready);
		got = pool_answer(op, sel, now, life);
		pending_answers.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SLOTS_IN_USE, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pool_len = (val[CFG_W-1:0] > POOL) ? POOL : val[CFG_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t unexpected result slot %0d granted %0d freed %0d", $time,
					m_axis_tdata[10:0], m_axis_tuser, m_axis_tdata[22:11]);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (m_axis_tdata[10:0] !== want.slot) begin
					$display("%0t slot expected %0d actual %0d", $time, want.slot,
						m_axis_tdata[10:0]);
					fail_count++;
				end
				if (m_axis_tuser !== want.granted) begin
					$display("%0t granted expected %0d actual %0d", $time, want.granted,
						m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[22:11] !== want.freed_count) begin
					$display("%0t freed_count expected %0d actual %0d", $time,
						want.freed_count, m_axis_tdata[22:11]);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side throttle, with a long hold-off on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	initial begin
		int k, ph, cnt, roll;
		logic [CMD_W-1:0]  op;
		logic              sel;
		logic [TICK_W-1:0] now, life, tbase;
		result_t want;
		row_t    row;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		hold_req = 0;
		snd_idle = 6;
		rcv_idle = 63;
		pool_len = SLOTS_RESET;
		free_top = NIL;
		ord_top = NIL;
		trc_top = NIL;
		for (k = 0; k < POOL; k++) begin
			succ[k] = '0;
			succ_ok[k] = 1'b0;
			stamp[k] = '0;
		end

		// is_cfg, cfg, cmd, sel, now, life, typed, slot, granted, freed
		dir_rows = '{
			// nothing linked before the first clear
			'{0, 0, CMD_ALLOC, 0, 0, 0, 1, 0, 0, 0},
			'{0, 0, CMD_SWEEP, 1, 32'hFFFF_FFFF, 0, 1, 0, 0, 0},
			'{0, 0, CMD_NONE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0},
			'{1, 2, CMD_NONE, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, CMD_CLEAR, 0, 0, 0, 1, 0, 0, 0},
			'{0, 0, CMD_ALLOC, 0, 0, 0, 1, 0, 1, 0},
			// saturated expiry on the tracer list
			'{0, 0, CMD_ALLOC, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 0},
			'{0, 0, CMD_ALLOC, 0, 7, 7, 1, 0, 0, 0},
			// expiry equal to now survives
			'{0, 0, CMD_SWEEP, 1, 32'hFFFF_FFFF, 0, 1, 0, 0, 0},
			'{0, 0, CMD_SWEEP, 0, 0, 0, 1, 0, 0, 0},
			'{0, 0, CMD_SWEEP, 0, 1, 0, 1, 0, 0, 1},
			'{0, 0, CMD_ALLOC, 0, 5, 10, 0, 0, 0, 0},
			'{1, 32'hFFFF_F001, CMD_NONE, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, CMD_CLEAR, 1, 32'h5555_5555, 32'hAAAA_AAAA, 1, 0, 0, 0},
			'{0, 0, CMD_ALLOC, 1, 100, 7, 1, 0, 1, 0},
			'{0, 0, CMD_ALLOC, 0, 100, 7, 1, 0, 0, 0},
			'{0, 0, CMD_SWEEP, 1, 200, 0, 1, 0, 0, 1},
			'{1, 0, CMD_NONE, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, CMD_CLEAR, 0, 0, 0, 1, 0, 0, 0},
			'{0, 0, CMD_ALLOC, 0, 3, 3, 1, 0, 0, 0},
			// out of range size behaves as the full pool
			'{1, 32'hAAAA_AFFF, CMD_NONE, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, CMD_CLEAR, 0, 0, 0, 1, 0, 0, 0},
			'{0, 0, CMD_ALLOC, 0, 10, 5, 0, 0, 0, 0},
			'{0, 0, CMD_ALLOC, 0, 10, 100, 0, 0, 0, 0},
			'{0, 0, CMD_ALLOC, 0, 10, 2, 0, 0, 0, 0},
			// frees the head and a slot behind a survivor
			'{0, 0, CMD_SWEEP, 0, 16, 0, 0, 0, 0, 0},
			'{0, 0, CMD_ALLOC, 1, 20, 0, 0, 0, 0, 0},
			'{0, 0, CMD_SWEEP, 0, 32'h8000_0000, 0, 0, 0, 0, 0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < N_DIR; k++) begin
			row = dir_rows[k];
			if (row.is_cfg) begin
				drain();
				apb_write(row.cfg_val);
			end else begin
				want.slot = row.w_slot;
				want.granted = row.w_granted;
				want.freed_count = row.w_freed;
				issue(row.cmd, row.sel, row.now, row.life, row.typed, want);
			end
		end

		for (ph = 0; ph < N_PHASE; ph++) begin
			drain();
			case (ph / 4)
				0: begin
					snd_idle = 6;
					rcv_idle = 63;
				end
				1: begin
					snd_idle = 63;
					rcv_idle = 6;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			case (ph)
				0: apb_write(($urandom & 32'hFFFF_F000) | 32'd16);
				1: apb_write(($urandom & 32'hFFFF_F000) | 32'd2);
				2: apb_write(($urandom & 32'hFFFF_F000) | 32'd6);
				3: apb_write(($urandom & 32'hFFFF_F000) | 32'd2048);
				4: apb_write(($urandom & 32'hFFFF_F000) | 32'd9);
				5: apb_write(($urandom & 32'hFFFF_F000) | 32'd3);
				6: apb_write(($urandom & 32'hFFFF_F000) | 32'd40);
				7: apb_write(($urandom & 32'hFFFF_F000) | 32'd4095);
				8: apb_write(($urandom & 32'hFFFF_F000) | 32'd2);
				9: apb_write(($urandom & 32'hFFFF_F000) | 32'd12);
				10: apb_write(($urandom & 32'hFFFF_F000) | 32'd5);
				default: apb_write(($urandom & 32'hFFFF_F000) | 32'd24);
			endcase
			// one phase per group runs just below the wrap of the time base
			tbase = (ph % 4 == 3) ? 32'hFFFF_FF00 : $urandom_range(0, 1000);
			want = '0;
			issue(CMD_CLEAR, $urandom_range(0, 1), $urandom, $urandom, 1'b0, want);
			cnt = 0;
			while (cnt < ITEMS_PER_PHASE) begin
				if (ph == 1 && cnt == 15)
					hold_req++;
				if (ph == 2 && cnt == 30)
					drain();
				roll = $urandom_range(0, 99);
				sel = $urandom_range(0, 1);
				now = tbase + $urandom_range(0, 3);
				life = $urandom_range(0, 40);
				if (roll < 48) begin
					op = CMD_ALLOC;
					roll = $urandom_range(0, 99);
					if (roll < 10)
						life = $urandom;
					else if (roll < 15)
						life = '1;
					else if (roll < 19)
						now = $urandom;
				end else if (roll < 86) begin
					op = CMD_SWEEP;
					now = tbase + $urandom_range(0, 40);
					if ($urandom_range(0, 99) < 5)
						now = $urandom;
				end else if (roll < 93) begin
					op = CMD_CLEAR;
				end else begin
					op = CMD_NONE;
					now = $urandom;
					life = $urandom;
				end
				if (op != CMD_NONE)
					cnt++;
				issue(op, sel, now, life, 1'b0, want);
				tbase = tbase + $urandom_range(0, 6);
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_answers.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
